// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the queue and back-end RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/fps_pkg.sv =====
package fps_pkg;

   localparam int ADDR_BITS_DEFAULT   = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int BUS_ADDR_BITS = 16;
   localparam int DATA_BITS     = 8;
   localparam int LIMIT_BITS    = 20;
   localparam int TICK_BITS     = 21;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 20'd100000;
   localparam logic [TICK_BITS-1:0]  TICK_MAX    = {TICK_BITS{1'b1}};

   // device command bytes
   localparam logic [DATA_BITS-1:0] CMD_PROGRAM = 8'h40;
   localparam logic [DATA_BITS-1:0] CMD_RESET   = 8'hFF;

   // status byte bit positions
   localparam int STAT_READY_BIT    = 1;
   localparam int STAT_PROTECT_BIT  = 3;
   localparam int STAT_INTERNAL_BIT = 4;
   localparam int STAT_VPP_BIT      = 5;

   // bus operation codes
   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   // result codes
   localparam logic [2:0] RC_OK       = 3'd0;
   localparam logic [2:0] RC_VPP      = 3'd1;
   localparam logic [2:0] RC_INTERNAL = 3'd2;
   localparam logic [2:0] RC_PROTECT  = 3'd3;
   localparam logic [2:0] RC_TIMEOUT  = 3'd4;
   localparam logic [2:0] RC_MISMATCH = 3'd5;

   typedef enum logic [1:0] {
      ACT_START,
      ACT_STATUS,
      ACT_READBACK,
      ACT_TICK
   } action_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_STATUS,
      PH_READBACK
   } phase_type;

   typedef struct packed {
      action_type                 action;
      logic [BUS_ADDR_BITS-1:0]   address;
      logic [DATA_BITS-1:0]       data;
   } req_word_type;

   typedef struct packed {
      logic [1:0]                 bus_op;
      logic [BUS_ADDR_BITS-1:0]   bus_address;
      logic [DATA_BITS-1:0]       bus_data;
      logic [2:0]                 result_code;
      logic                       last;
   } rsp_word_type;

   // work handed from the front to the back
   typedef enum logic [2:0] {
      JOB_START,         // program cmd, data write, status read
      JOB_READ_ADDR,     // read back target address
      JOB_RESET_FINISH,  // reset write, then finish
      JOB_RESET_READ0,   // reset write, then status read
      JOB_READ0,         // status read
      JOB_FINISH         // finish only
   } job_kind_type;

   typedef struct packed {
      job_kind_type               kind;
      logic [BUS_ADDR_BITS-1:0]   addr;
      logic [DATA_BITS-1:0]       data;
      logic [2:0]                 code;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [1:0] job_beats(job_kind_type kind);
      logic [1:0] beats;
      unique case (kind)
         JOB_START:        beats = 2'd3;
         JOB_RESET_FINISH: beats = 2'd2;
         JOB_RESET_READ0:  beats = 2'd2;
         default:          beats = 2'd1;
      endcase
      return beats;
   endfunction

endpackage

// ===== hw/rtl/fps_front.sv =====
module fps_front #(
   parameter int ADDR_BITS = fps_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  fps_pkg::req_word_type           req_word,
   input  logic                            csr_write_enable,
   input  logic [fps_pkg::LIMIT_BITS-1:0]  csr_write_data,
   input  fps_pkg::q_status_type           q_status,
   output logic                            job_push,
   output fps_pkg::job_type                job_word
);
   import fps_pkg::*;

   localparam int SAVE_BITS = (ADDR_BITS < BUS_ADDR_BITS) ? ADDR_BITS : BUS_ADDR_BITS;

   phase_type               phase_ff, phase_in;
   logic [SAVE_BITS-1:0]    saddr_ff, saddr_in;
   logic [DATA_BITS-1:0]    sdata_ff, sdata_in;
   logic [TICK_BITS-1:0]    ticks_ff, ticks_in;
   logic [LIMIT_BITS-1:0]   limit_ff, limit_in;

   logic       accept;
   logic       busy;
   logic       stat_ready;
   logic       stat_err;
   logic [2:0] err_code;
   logic [2:0] fin_code;
   logic       job_valid;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign busy      = (phase_ff == PH_STATUS) || (phase_ff == PH_READBACK);
   assign job_push  = accept && job_valid;

   // status byte decode
   assign stat_ready = req_word.data[STAT_READY_BIT];
   assign stat_err   = req_word.data != '0;

   always_comb begin
      priority if (req_word.data[STAT_VPP_BIT]) begin
         err_code = RC_VPP;
      end else if (req_word.data[STAT_INTERNAL_BIT]) begin
         err_code = RC_INTERNAL;
      end else if (req_word.data[STAT_PROTECT_BIT]) begin
         err_code = RC_PROTECT;
      end else begin
         err_code = RC_OK;
      end
   end

   assign fin_code = (err_code != RC_OK) ? err_code :
                     (ticks_ff > {1'b0, limit_ff}) ? RC_TIMEOUT : RC_OK;

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (req_word.action)
            ACT_START: begin
               if (!busy) phase_in = PH_STATUS;
            end
            ACT_STATUS: begin
               if (phase_ff == PH_STATUS) begin
                  if (stat_ready) begin
                     phase_in = PH_READBACK;
                  end else if (fin_code != RC_OK) begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            ACT_READBACK: begin
               if (phase_ff == PH_READBACK) phase_in = PH_IDLE;
            end
            ACT_TICK: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // job out
   always_comb begin
      job_valid     = 1'b0;
      job_word.kind = JOB_FINISH;
      job_word.addr = BUS_ADDR_BITS'(saddr_ff);
      job_word.data = sdata_ff;
      job_word.code = RC_OK;
      unique case (req_word.action)
         ACT_START: begin
            job_valid     = !busy;
            job_word.kind = JOB_START;
            job_word.addr = BUS_ADDR_BITS'(req_word.address[SAVE_BITS-1:0]);
            job_word.data = req_word.data;
         end
         ACT_STATUS: begin
            job_valid = phase_ff == PH_STATUS;
            if (stat_ready) begin
               job_word.kind = JOB_READ_ADDR;
            end else if (fin_code != RC_OK) begin
               job_word.kind = stat_err ? JOB_RESET_FINISH : JOB_FINISH;
               job_word.code = fin_code;
            end else begin
               job_word.kind = stat_err ? JOB_RESET_READ0 : JOB_READ0;
            end
         end
         ACT_READBACK: begin
            job_valid     = phase_ff == PH_READBACK;
            job_word.kind = JOB_FINISH;
            job_word.code = (req_word.data == sdata_ff) ? RC_OK : RC_MISMATCH;
         end
         ACT_TICK: begin
            job_valid = 1'b0;
         end
      endcase
   end

   // saved request, tick counter, limit
   always_comb begin
      saddr_in = saddr_ff;
      sdata_in = sdata_ff;
      ticks_in = ticks_ff;
      limit_in = csr_write_enable ? csr_write_data : limit_ff;
      if (accept && req_word.action == ACT_START && !busy) begin
         saddr_in = req_word.address[SAVE_BITS-1:0];
         sdata_in = req_word.data;
         ticks_in = '0;
      end else if (accept && req_word.action == ACT_TICK && ticks_ff != TICK_MAX) begin
         ticks_in = ticks_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         saddr_ff <= '0;
         sdata_ff <= '0;
         ticks_ff <= '0;
         limit_ff <= LIMIT_RESET;
      end else begin
         phase_ff <= phase_in;
         saddr_ff <= saddr_in;
         sdata_ff <= sdata_in;
         ticks_ff <= ticks_in;
         limit_ff <= limit_in;
      end
   end

endmodule

// ===== hw/rtl/fps_queue.sv =====
`include "assert_macros.svh"

module fps_queue #(
   parameter int DEPTH = fps_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  fps_pkg::job_type        push_word,
   input  logic                    pop,
   output fps_pkg::job_type        head_word,
   output fps_pkg::q_status_type   status
);
   import fps_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);

   job_type               slot_ff [DEPTH];
   logic [PTR_BITS-1:0]   wptr_ff, wptr_in;
   logic [PTR_BITS-1:0]   rptr_ff, rptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   assign status.full  = count_ff == CNT_BITS'(DEPTH);
   assign status.empty = count_ff == '0;
   assign head_word    = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) wptr_in = (wptr_ff == PTR_LAST) ? '0 : wptr_ff + 1'b1;
      if (pop)  rptr_in = (rptr_ff == PTR_LAST) ? '0 : rptr_ff + 1'b1;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wptr_ff] <= push_word;
   end

   `ASSERT_HOLDS(a_count_bound, clock, reset, count_ff <= CNT_BITS'(DEPTH))
   `ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == CNT_BITS'($past(count_ff) + 1'b1))
   `ASSERT_NEXT(a_head_holds, clock, reset, !pop && !status.empty, $stable(head_word))

endmodule

// ===== hw/rtl/fps_back.sv =====
`include "assert_macros.svh"

module fps_back (
   input  logic                    clock,
   input  logic                    reset,
   input  fps_pkg::job_type        job_head,
   input  fps_pkg::q_status_type   q_status,
   output logic                    job_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output fps_pkg::rsp_word_type   rsp_word
);
   import fps_pkg::*;

   logic [1:0]     beat_ff, beat_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_word_type   rsp_word_ff, rsp_word_in;

   logic load;
   logic last_beat;

   assign load      = !q_status.empty && (!rsp_valid_ff || rsp_ready);
   assign last_beat = beat_ff == (job_beats(job_head.kind) - 2'd1);
   assign job_pop   = load && last_beat;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      beat_in      = beat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load) begin
         beat_in      = last_beat ? 2'd0 : beat_ff + 2'd1;
         rsp_valid_in = 1'b1;
      end
   end

   // expand current beat of the head job into one bus word
   always_comb begin
      rsp_word_in.bus_op      = OP_READ;
      rsp_word_in.bus_address = '0;
      rsp_word_in.bus_data    = '0;
      rsp_word_in.result_code = RC_OK;
      rsp_word_in.last        = last_beat;
      unique case (job_head.kind)
         JOB_START: begin
            priority if (beat_ff == 2'd0) begin
               rsp_word_in.bus_op   = OP_WRITE;
               rsp_word_in.bus_data = CMD_PROGRAM;
            end else if (beat_ff == 2'd1) begin
               rsp_word_in.bus_op      = OP_WRITE;
               rsp_word_in.bus_address = job_head.addr;
               rsp_word_in.bus_data    = job_head.data;
            end else begin
               rsp_word_in.bus_op = OP_READ;
            end
         end
         JOB_READ_ADDR: begin
            rsp_word_in.bus_address = job_head.addr;
         end
         JOB_RESET_FINISH: begin
            if (beat_ff == 2'd0) begin
               rsp_word_in.bus_op   = OP_WRITE;
               rsp_word_in.bus_data = CMD_RESET;
            end else begin
               rsp_word_in.bus_op      = OP_FINISH;
               rsp_word_in.result_code = job_head.code;
            end
         end
         JOB_RESET_READ0: begin
            if (beat_ff == 2'd0) begin
               rsp_word_in.bus_op   = OP_WRITE;
               rsp_word_in.bus_data = CMD_RESET;
            end
         end
         JOB_READ0: begin
            rsp_word_in.bus_op = OP_READ;
         end
         default: begin
            rsp_word_in.bus_op      = OP_FINISH;
            rsp_word_in.result_code = job_head.code;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) rsp_word_ff <= rsp_word_in;
   end

   `ASSERT_IMPLIES(a_beat_has_job, clock, reset, beat_ff != 2'd0, !q_status.empty)
   `ASSERT_IMPLIES(a_beat_in_range, clock, reset, !q_status.empty, beat_ff < job_beats(job_head.kind))
   `ASSERT_IMPLIES(a_finish_is_last, clock, reset, rsp_valid_ff && rsp_word_ff.bus_op == OP_FINISH, rsp_word_ff.last)

endmodule

// ===== hw/rtl/flash_program_sequencer.sv =====
// Flash byte-program sequencer.
// req channel (valid/ready): one word per event: start (address, data),
// status byte returned, readback byte returned, or a microsecond tick.
// rsp channel (valid/ready): device bus words (write, read) and a final
// "finished" word with the result code; last marks the final word caused
// by one request word.
// csr port: one write-enabled register, the timeout limit in ticks.
// A request's job is written into the job queue when it is accepted; the
// back end loads its words into the rsp register. A start produces three
// words, a status reply one or two, a readback reply one, a tick none.
// Throughput: one request word per cycle while the job queue has room;
// the back end drains one response word per cycle unless rsp stalls,
// so the output rate is set by the word count of each job.
// Reset (synchronous) empties the queue, drops any pending response,
// returns to idle, clears the tick count and restores the default limit.
// A stalled rsp side holds its word; requests keep flowing into the
// queue until it fills, then req_ready drops.
module flash_program_sequencer #(
   parameter int ADDR_BITS   = fps_pkg::ADDR_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = fps_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  fps_pkg::req_word_type           req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output fps_pkg::rsp_word_type           rsp_word,
   input  logic                            csr_write_enable,
   input  logic [fps_pkg::LIMIT_BITS-1:0]  csr_write_data
);
   import fps_pkg::*;

   // front -> queue
   logic           job_push;
   job_type        job_word;
   // queue -> back
   job_type        job_head;
   q_status_type   q_status;
   logic           job_pop;

   // front: decodes each request against the phase, updates saved
   // address/data and the tick counter, and queues the bus job.
   fps_front #(
      .ADDR_BITS (ADDR_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word         (req_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_status         (q_status),
      .job_push         (job_push),
      .job_word         (job_word)
   );

   // short job queue decoupling the two sides
   fps_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_word (job_word),
      .pop       (job_pop),
      .head_word (job_head),
      .status    (q_status)
   );

   // back: expands each job into one to three registered bus words
   fps_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_head  (job_head),
      .q_status  (q_status),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== tb/sv/tb_flash_program_sequencer.sv =====
module tb_flash_program_sequencer;
   import fps_pkg::*;

   // Tracks the sequencer state as request words are accepted and holds
   // the response words each accepted word is due to produce.
   class program_tracker;
      rsp_word_type                bus_words_due[$];
      logic [LIMIT_BITS-1:0]       limit_us;
      phase_type                   phase;
      logic [BUS_ADDR_BITS-1:0]    saved_address;
      logic [DATA_BITS-1:0]        saved_data;
      logic [TICK_BITS-1:0]        ticks;
      int                          errors;
      int                          words_taken;
      int                          words_acted;
      int                          words_checked;
      int                          finish_codes[6];

      function new();
         limit_us      = LIMIT_RESET;
         phase         = PH_IDLE;
         saved_address = '0;
         saved_data    = '0;
         ticks         = '0;
         errors        = 0;
         words_taken   = 0;
         words_acted   = 0;
         words_checked = 0;
         foreach (finish_codes[i]) finish_codes[i] = 0;
      endfunction

      function void set_limit(logic [LIMIT_BITS-1:0] value);
         limit_us = value;
      endfunction

      function rsp_word_type bus_word(logic [1:0] op, logic [BUS_ADDR_BITS-1:0] addr,
                                      logic [DATA_BITS-1:0] data, logic [2:0] code);
         rsp_word_type w;
         w.bus_op      = op;
         w.bus_address = addr;
         w.bus_data    = data;
         w.result_code = code;
         w.last        = 1'b0;
         return w;
      endfunction

      // Returns 1 when the word changed state, caused responses or was a tick.
      function bit note(req_word_type w);
         rsp_word_type batch[$];
         logic [2:0]   code;
         bit           took;
         took = 1'b0;
         words_taken++;
         case (w.action)
            ACT_START: if (phase == PH_IDLE) begin
               took          = 1'b1;
               saved_address = w.address;
               saved_data    = w.data;
               ticks         = '0;
               batch.push_back(bus_word(OP_WRITE, '0, CMD_PROGRAM, RC_OK));
               batch.push_back(bus_word(OP_WRITE, saved_address, saved_data, RC_OK));
               batch.push_back(bus_word(OP_READ, '0, '0, RC_OK));
               phase = PH_STATUS;
            end
            ACT_STATUS: if (phase == PH_STATUS) begin
               took = 1'b1;
               if (w.data[STAT_READY_BIT]) begin
                  batch.push_back(bus_word(OP_READ, saved_address, '0, RC_OK));
                  phase = PH_READBACK;
               end else begin
                  code = RC_OK;
                  if (w.data != '0) begin
                     // any nonzero, not-ready status resets the device first
                     batch.push_back(bus_word(OP_WRITE, '0, CMD_RESET, RC_OK));
                     if (w.data[STAT_VPP_BIT])
                        code = RC_VPP;
                     else if (w.data[STAT_INTERNAL_BIT])
                        code = RC_INTERNAL;
                     else if (w.data[STAT_PROTECT_BIT])
                        code = RC_PROTECT;
                  end
                  if (code == RC_OK && ticks > TICK_BITS'(limit_us))
                     code = RC_TIMEOUT;
                  if (code != RC_OK) begin
                     batch.push_back(bus_word(OP_FINISH, '0, '0, code));
                     finish_codes[code]++;
                     phase = PH_IDLE;
                  end else begin
                     batch.push_back(bus_word(OP_READ, '0, '0, RC_OK));
                  end
               end
            end
            ACT_READBACK: if (phase == PH_READBACK) begin
               took = 1'b1;
               code = (w.data == saved_data) ? RC_OK : RC_MISMATCH;
               batch.push_back(bus_word(OP_FINISH, '0, '0, code));
               finish_codes[code]++;
               phase = PH_IDLE;
            end
            default: begin
               // tick: counted in every phase, saturating
               took = 1'b1;
               if (ticks != TICK_MAX)
                  ticks = ticks + 1'b1;
            end
         endcase
         if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
         foreach (batch[i]) bus_words_due.push_back(batch[i]);
         if (took)
            words_acted++;
         return took;
      endfunction

      function void check(rsp_word_type got);
         rsp_word_type want;
         words_checked++;
         if (bus_words_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected rsp word: op %0d addr %h data %h code %0d last %0d",
                        got.bus_op, got.bus_address, got.bus_data, got.result_code,
                        got.last);
            return;
         end
         want = bus_words_due.pop_front();
         if (got.bus_op !== want.bus_op || got.bus_address !== want.bus_address ||
             got.bus_data !== want.bus_data || got.result_code !== want.result_code ||
             got.last !== want.last) begin
            errors++;
            if (errors <= 10)
               $display({"rsp mismatch: exp op %0d addr %h data %h code %0d last %0d,",
                         " got op %0d addr %h data %h code %0d last %0d"},
                        want.bus_op, want.bus_address, want.bus_data, want.result_code,
                        want.last, got.bus_op, got.bus_address, got.bus_data,
                        got.result_code, got.last);
         end
      endfunction

      function int pending();
         return bus_words_due.size();
      endfunction

      function void final_check();
         if (bus_words_due.size() != 0) begin
            errors++;
            $display("%0d rsp words never arrived", bus_words_due.size());
         end
      endfunction
   endclass

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   req_word_type           req_word         = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   rsp_word_type           rsp_word;
   logic                   csr_write_enable = 1'b0;
   logic [LIMIT_BITS-1:0]  csr_write_data   = '0;

   program_tracker tracker;
   bit             last_took;
   bit             calm = 1'b0;   // stretch with no idling on either side
   int             ready_hold = 0;

   flash_program_sequencer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Gap length: mostly short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14)
         return $urandom_range(1, 2);
      else if (r < 19)
         return $urandom_range(3, 6);
      return $urandom_range(15, 40);
   endfunction

   // Flip between idling and no-idling stretches.
   always begin
      repeat ($urandom_range(100, 300)) @(negedge clock);
      calm <= ~calm;
   end

   // Receiver stalls.
   always @(negedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
         rsp_ready  <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
         ready_hold <= pick_gap();
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready  <= 1'b1;
      end
   end

   // Response monitor: every accepted word checked against the oldest due word.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check(rsp_word);
   end

   function automatic req_word_type make_word(action_type act, logic [BUS_ADDR_BITS-1:0] addr,
                                              logic [DATA_BITS-1:0] data);
      req_word_type w;
      w.action  = act;
      w.address = addr;
      w.data    = data;
      return w;
   endfunction

   // Drive one request word from the falling edge; hold until accepted.
   task automatic send_word(input req_word_type w);
      int gap;
      gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      last_took = tracker.note(w);
   endtask

   // Sender holds off until every due response word has come.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // Drained, plus quiet cycles with no request.
   task automatic settle();
      drain_results();
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
      settle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      tracker.set_limit(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly well-formed program sequences steered by the tracked phase,
   // with some noise words of any action.
   function automatic req_word_type next_word();
      req_word_type w;
      int           pick;
      int           kind;
      logic [7:0]   b;
      w    = make_word(ACT_TICK, 16'($urandom), 8'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         w.action = action_type'(2'($urandom_range(0, 3)));
      end else begin
         case (tracker.phase)
            PH_STATUS: begin
               if (pick < 50) begin
                  w.action = ACT_TICK;
               end else begin
                  w.action = ACT_STATUS;
                  kind     = $urandom_range(0, 9);
                  b        = 8'($urandom);
                  if (kind < 4) begin
                     b = '0;                             // busy, no bits
                  end else if (kind < 6) begin
                     b[STAT_READY_BIT] = 1'b1;           // ready
                  end else if (kind < 8) begin
                     b[STAT_READY_BIT] = 1'b0;           // at least one error bit
                     b[STAT_PROTECT_BIT + $urandom_range(0, 2)] = 1'b1;
                  end else if (kind < 9) begin
                     b[STAT_READY_BIT]    = 1'b0;        // other bits only
                     b[STAT_PROTECT_BIT]  = 1'b0;
                     b[STAT_INTERNAL_BIT] = 1'b0;
                     b[STAT_VPP_BIT]      = 1'b0;
                  end
                  w.data = b;
               end
            end
            PH_READBACK: begin
               if (pick < 30) begin
                  w.action = ACT_TICK;
               end else begin
                  w.action = ACT_READBACK;
                  if ($urandom_range(0, 3) != 0)
                     w.data = tracker.saved_data;
               end
            end
            default: w.action = ACT_START;
         endcase
      end
      return w;
   endfunction

   task automatic run_random(input int count);
      int taken;
      taken = 0;
      while (taken < count) begin
         if ($urandom_range(0, 49) == 0)
            drain_results();
         send_word(next_word());
         if (last_took)
            taken++;
      end
   endtask

   initial begin
      tracker = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset limit: stray words, full write, poll paths, each error.
      send_word(make_word(ACT_STATUS, 16'h0000, 8'h02));     // idle: dropped
      send_word(make_word(ACT_READBACK, 16'hFFFF, 8'h00));   // idle: dropped
      send_word(make_word(ACT_TICK, 16'h0000, 8'h00));
      send_word(make_word(ACT_START, 16'hFFFF, 8'hFF));
      send_word(make_word(ACT_START, 16'h1234, 8'h55));      // busy: dropped
      send_word(make_word(ACT_READBACK, 16'h0000, 8'h00));   // wrong phase
      send_word(make_word(ACT_STATUS, 16'h0000, 8'h00));     // poll again
      send_word(make_word(ACT_STATUS, 16'h0000, 8'h80));     // reset write, poll
      send_word(make_word(ACT_STATUS, 16'hFFFF, 8'hFF));     // ready wins
      send_word(make_word(ACT_STATUS, 16'h0000, 8'h00));     // wrong phase
      send_word(make_word(ACT_START, 16'h0001, 8'h01));      // busy: dropped
      send_word(make_word(ACT_READBACK, 16'h0000, 8'hFF));   // match
      send_word(make_word(ACT_START, 16'h0000, 8'h00));
      send_word(make_word(ACT_STATUS, 16'h0000, 8'h38));     // vpp over the rest
      send_word(make_word(ACT_START, 16'h8001, 8'hA5));
      send_word(make_word(ACT_STATUS, 16'h0000, 8'h18));     // internal over protect
      send_word(make_word(ACT_START, 16'h7FFE, 8'h5A));
      send_word(make_word(ACT_STATUS, 16'h0000, 8'h08));     // protected
      send_word(make_word(ACT_START, 16'h00FF, 8'h3C));
      send_word(make_word(ACT_STATUS, 16'h0000, 8'h02));
      send_word(make_word(ACT_READBACK, 16'h0000, 8'hC3));   // mismatch

      // Zero limit: timeout only once a tick has been counted.
      write_limit('0);
      send_word(make_word(ACT_START, 16'hAAAA, 8'h01));
      send_word(make_word(ACT_STATUS, 16'h0000, 8'h00));     // 0 > 0 fails: poll
      send_word(make_word(ACT_TICK, 16'hFFFF, 8'hFF));
      send_word(make_word(ACT_STATUS, 16'h0000, 8'h40));     // reset write, timeout
      send_word(make_word(ACT_START, 16'h5555, 8'h80));
      send_word(make_word(ACT_TICK, 16'h0000, 8'h00));
      send_word(make_word(ACT_STATUS, 16'h0000, 8'h00));     // plain timeout

      // Random phases across limit settings, extremes included.
      write_limit(20'hFFFFF);
      run_random(40);
      write_limit('0);
      run_random(40);
      write_limit(20'($urandom_range(1, 6)));
      run_random(40);
      write_limit(LIMIT_RESET);
      run_random(40);
      write_limit(20'($urandom_range(2, 10)));
      run_random(40);
      write_limit(20'($urandom_range(0, 3)));
      run_random(40);

      settle();
      repeat (8) @(posedge clock);
      tracker.final_check();
      $display("covered %0d request words (%0d acted on), %0d response words, limits 0 to max",
               tracker.words_taken, tracker.words_acted, tracker.words_checked);
      $display("finishes: ok %0d vpp %0d internal %0d protect %0d timeout %0d mismatch %0d",
               tracker.finish_codes[RC_OK], tracker.finish_codes[RC_VPP],
               tracker.finish_codes[RC_INTERNAL], tracker.finish_codes[RC_PROTECT],
               tracker.finish_codes[RC_TIMEOUT], tracker.finish_codes[RC_MISMATCH]);
      if (tracker.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d errors", tracker.errors);
         $display("TEST FAILED");
      end
      $finish;
   end

   // Run limit, well past the slowest legal run.
   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
